// ===== hdl/mcvs_pkg.sv =====
// ----------------------------------------------------------------------------
// mcvs_pkg
// Shared types and constants of the MIDI channel volume scaler.
// ----------------------------------------------------------------------------
package mcvs_pkg;

   localparam int unsigned MASTER_W = 9;
   localparam int unsigned VOL_W    = 8;
   localparam int unsigned CHAN_W   = 4;

   localparam logic [MASTER_W-1:0] MASTER_FULL = 9'd256;
   localparam logic [VOL_W-1:0]    VOL_MAX     = 8'd127;
   localparam logic [7:0]          META_STATUS = 8'hFF;
   localparam logic [7:0]          CC_STATUS   = 8'hB0;
   localparam logic [7:0]          CC_VOLUME   = 8'h07;
   localparam logic [7:0]          HIGH_NIBBLE = 8'hF0;
   localparam logic [7:0]          LOW_NIBBLE  = 8'h0F;
   localparam logic [1:0]          LEN_CC      = 2'd3;

   typedef enum logic [1:0] {
      OP_FILTER = 2'd0,
      OP_RESET  = 2'd1,
      OP_SWEEP  = 2'd2
   } opcode_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [1:0] msg_length;
      logic [7:0] msg_status;
      logic [7:0] msg_data_one;
      logic [7:0] msg_data_two;
   } req_data_type;

   typedef struct packed {
      logic [1:0] out_length;
      logic [7:0] out_status;
      logic [7:0] out_data_one;
      logic [7:0] out_data_two;
      logic       last_of_run;
   } rsp_data_type;

   typedef struct packed {
      logic              wr_en;
      logic              set_all;
      logic [CHAN_W-1:0] chan;
      logic [VOL_W-1:0]  vol;
   } store_ctl_type;

endpackage

// ===== hdl/mcvs_vol_store.sv =====
// ----------------------------------------------------------------------------
// mcvs_vol_store
// Requested volume per channel: single write, preset of all channels, one
// read port addressed by the sweep counter.
// ----------------------------------------------------------------------------
module mcvs_vol_store
   import mcvs_pkg::*;
#(
   parameter int CHANNELS = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  store_ctl_type                               ctl,
   input  logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] rd_addr,
   output logic [VOL_W-1:0]                            rd_data
);

   localparam int CH_W = CHANNELS > 1 ? $clog2(CHANNELS) : 1;

   logic [VOL_W-1:0] vol_ff [CHANNELS];
   logic             chan_ok;

   assign chan_ok = {1'b0, ctl.chan} < (CHAN_W + 1)'(CHANNELS);
   assign rd_data = vol_ff[rd_addr];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            vol_ff[i] <= '0;
         end
      end else if (ctl.set_all) begin
         for (int i = 0; i < CHANNELS; i++) begin
            vol_ff[i] <= VOL_MAX;
         end
      end else if (ctl.wr_en && chan_ok) begin
         vol_ff[ctl.chan[CH_W-1:0]] <= ctl.vol;
      end
   end

endmodule

// ===== hdl/mcvs_scaler.sv =====
// ----------------------------------------------------------------------------
// mcvs_scaler
// Shared scaling unit: saturate master, multiply, round half up, cap at 127.
// ----------------------------------------------------------------------------
module mcvs_scaler
   import mcvs_pkg::*;
(
   input  logic [MASTER_W-1:0] master,
   input  logic [VOL_W-1:0]    vol,
   output logic [VOL_W-1:0]    scaled
);

   logic [MASTER_W-1:0]       master_sat;
   logic [MASTER_W+VOL_W-1:0] product;
   logic [MASTER_W+VOL_W-1:0] rounded;
   logic [MASTER_W-1:0]       shifted;

   assign master_sat = (master > MASTER_FULL) ? MASTER_FULL : master;
   assign product    = (MASTER_W + VOL_W)'(master_sat) * (MASTER_W + VOL_W)'(vol);
   assign rounded    = product + (MASTER_W + VOL_W)'(128);
   assign shifted    = rounded[MASTER_W+VOL_W-1:8];
   assign scaled     = (shifted > MASTER_W'(VOL_MAX)) ? VOL_MAX : shifted[VOL_W-1:0];

endmodule

// ===== hdl/mcvs_seq.sv =====
// ----------------------------------------------------------------------------
// mcvs_seq
// Sequencer: decode transactions, pass messages through, step the channel
// sweep through the shared scaler and hold the result register.
// ----------------------------------------------------------------------------
module mcvs_seq
   import mcvs_pkg::*;
#(
   parameter int CHANNELS = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  req_data_type                                req_data,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output rsp_data_type                                rsp_data,
   output store_ctl_type                               store_ctl,
   output logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] rd_addr,
   input  logic [VOL_W-1:0]                            scaled
);

   localparam int CH_W = CHANNELS > 1 ? $clog2(CHANNELS) : 1;

   typedef enum logic {
      ST_IDLE,
      ST_SWEEP
   } state_type;

   state_type    state_ff, state_in;
   logic [CH_W-1:0] cnt_ff, cnt_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   logic slot_free;
   logic accept;
   logic is_cc;
   logic cnt_last;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rd_addr   = cnt_ff;
   assign cnt_last  = cnt_ff == CH_W'(CHANNELS - 1);

   assign is_cc = (req_data.msg_length == LEN_CC)
               && ((req_data.msg_status & HIGH_NIBBLE) == CC_STATUS)
               && (req_data.msg_data_one == CC_VOLUME);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      store_ctl    = '0;
      store_ctl.chan = 4'(req_data.msg_status & LOW_NIBBLE);
      store_ctl.vol  = req_data.msg_data_two;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.opcode)
                  OP_FILTER: begin
                     if (req_data.msg_length == 2'd0 || req_data.msg_status == META_STATUS) begin
                        state_in = ST_IDLE;
                     end else if (is_cc) begin
                        store_ctl.wr_en = 1'b1;
                        cnt_in          = '0;
                        state_in        = ST_SWEEP;
                     end else begin
                        rsp_valid_in             = 1'b1;
                        rsp_data_in.out_length   = req_data.msg_length;
                        rsp_data_in.out_status   = req_data.msg_status;
                        rsp_data_in.out_data_one = (req_data.msg_length >= 2'd2)
                                                   ? req_data.msg_data_one : 8'd0;
                        rsp_data_in.out_data_two = (req_data.msg_length >= 2'd3)
                                                   ? req_data.msg_data_two : 8'd0;
                        rsp_data_in.last_of_run  = 1'b1;
                     end
                  end
                  OP_RESET: begin
                     store_ctl.set_all = 1'b1;
                     cnt_in            = '0;
                     state_in          = ST_SWEEP;
                  end
                  OP_SWEEP: begin
                     cnt_in   = '0;
                     state_in = ST_SWEEP;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            if (slot_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.out_length   = LEN_CC;
               rsp_data_in.out_status   = CC_STATUS + 8'(cnt_ff);
               rsp_data_in.out_data_one = CC_VOLUME;
               rsp_data_in.out_data_two = scaled;
               rsp_data_in.last_of_run  = cnt_last;
               if (cnt_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + CH_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== hdl/midi_channel_volume_scaler_top.sv =====
// ----------------------------------------------------------------------------
// midi_channel_volume_scaler_top
// Filters MIDI messages and turns channel-volume changes into a scaled
// volume sweep over all channels.
// ----------------------------------------------------------------------------
// A pass-through message is accepted and its result transaction is presented
// the next cycle. Opcodes 1 and 2 and a channel-volume change are accepted and
// then sweep all CHANNELS channels, one result transaction per cycle while
// rsp_ready stays high, as the sweep counter steps the one shared scaler
// through the volume store; req_ready is low for the whole sweep.
// Dropped messages and opcode 3 are accepted and give no result.
// master_volume sits at byte address 0 of the register port.
module midi_channel_volume_scaler_top
   import mcvs_pkg::*;
#(
   parameter int CHANNELS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int CH_W = CHANNELS > 1 ? $clog2(CHANNELS) : 1;

   logic [MASTER_W-1:0] master_ff, master_in;
   store_ctl_type       store_ctl;
   logic [CH_W-1:0]     rd_addr;
   logic [VOL_W-1:0]    rd_data;
   logic [VOL_W-1:0]    scaled;
   logic                csr_write;
   logic                csr_hit;

   assign pready    = 1'b1;
   assign csr_hit   = paddr[2] == 1'b0;
   assign csr_write = psel && penable && pwrite && pready && csr_hit;
   assign master_in = csr_write ? pwdata[MASTER_W-1:0] : master_ff;
   assign prdata    = csr_hit ? 32'(master_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff <= MASTER_FULL;
      end else begin
         master_ff <= master_in;
      end
   end

   mcvs_vol_store #(
      .CHANNELS (CHANNELS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (store_ctl),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mcvs_scaler u_scaler (
      .master (master_ff),
      .vol    (rd_data),
      .scaled (scaled)
   );

   mcvs_seq #(
      .CHANNELS (CHANNELS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .store_ctl (store_ctl),
      .rd_addr   (rd_addr),
      .scaled    (scaled)
   );

endmodule
